// ===== rtl/assert_macros.svh =====
// assertion macros used by the solver core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define KP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define KP_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define KP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/kp_pkg.sv =====
// shared types and fixed field widths of the knapsack solver
package kp_pkg;

    localparam int CAP_W    = 6;
    localparam int WGT_W    = 6;
    localparam int PRF_IN_W = 16;
    localparam int NUM_W    = 5;
    localparam int VAL_W    = 20;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SWEEP   = 6'b000010,
        ST_DRAIN   = 6'b000100,
        ST_STORE   = 6'b001000,
        ST_TB_CHK  = 6'b010000,
        ST_TB_EVAL = 6'b100000
    } t_state;

endpackage

// ===== rtl/kp_ifs.sv =====
// valid/ready channel interfaces for configuration, input items and results

interface kp_cfg_if;
    import kp_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kp_item_if;
    import kp_pkg::*;
    logic                valid;
    logic                ready;
    logic [WGT_W-1:0]    item_weight;
    logic [PRF_IN_W-1:0] item_profit;
    logic                last_item;
    modport source (output valid, output item_weight, output item_profit,
                    output last_item, input ready);
    modport sink   (input valid, input item_weight, input item_profit,
                    input last_item, output ready);
endinterface

interface kp_res_if;
    import kp_pkg::*;
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] item_number;
    logic             selected;
    logic [VAL_W-1:0] total_profit;
    logic             overflow;
    logic             last_result;
    modport source (output valid, output item_number, output selected,
                    output total_profit, output overflow, output last_result,
                    input ready);
    modport sink   (input valid, input item_number, input selected,
                    input total_profit, input overflow, input last_result,
                    output ready);
endinterface

// ===== rtl/kp_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
module kp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/knapsack_01_solver_core.sv =====
// 0/1 knapsack solver: each loaded item sweeps the best-value row over all
// capacities MAX_CAPACITY down to 0 through one shared saturating adder and
// comparator, one capacity entry per cycle; a loaded item passes through
// acceptance, the sweep, a pipeline drain state and a state that stores the
// item's take row, and the input is not ready during that time. A dropped
// item (more than MAX_ITEMS) is taken in the idle state with no sweep. After
// the last item the traceback reads one stored item per step from the item
// memory, passing through a check state and an evaluate state per visited
// item and then giving the total result, and it stalls while a result is not
// taken. The best-value row is cleared at the end of each problem through
// per-entry valid bits, with no clearing pass. The capacity register is
// sampled when the traceback starts and is clamped to MAX_CAPACITY.
`include "assert_macros.svh"

module knapsack_01_solver_core #(
    parameter int MAX_ITEMS    = 16,
    parameter int MAX_CAPACITY = 63,
    parameter int PROFIT_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kp_cfg_if.sink    i_cfg,
    kp_item_if.sink   i_item,
    kp_res_if.source  o_res
);

    import kp_pkg::*;

    localparam int NC = MAX_CAPACITY + 1;
    localparam int CW = $clog2(NC);
    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int XW = ((CW > WGT_W) ? CW : WGT_W) + 1;
    localparam int SW = ((PROFIT_BITS > VAL_W) ? PROFIT_BITS : VAL_W) + 1;
    localparam int DW = NC + WGT_W + PROFIT_BITS;

    // control state
    t_state           r_state, n_state;
    logic [CAP_W-1:0] r_cap, n_cap;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic             r_drop, n_drop;
    logic [NC-1:0]    r_rv, n_rv;
    logic             r_s1_vld, n_s1_vld;
    logic             r_ov, n_ov;

    // datapath registers
    logic [WGT_W-1:0]       r_w, n_w;
    logic [PROFIT_BITS-1:0] r_p, n_p;
    logic                   r_last, n_last;
    logic [CW-1:0]          r_j, n_j;
    logic [NC-1:0]          r_take, n_take;
    logic [CW-1:0]          r_s1_j, n_s1_j;
    logic                   r_s1_ok, n_s1_ok;
    logic                   r_s1_va, n_s1_va;
    logic                   r_s1_vb, n_s1_vb;
    logic [IW-1:0]          r_i, n_i;
    logic [CW-1:0]          r_tj, n_tj;
    logic [VAL_W-1:0]       r_sum, n_sum;
    logic [NUM_W-1:0]       r_onum, n_onum;
    logic                   r_osel, n_osel;
    logic [VAL_W-1:0]       r_otot, n_otot;
    logic                   r_oovf, n_oovf;
    logic                   r_olast, n_olast;

    logic                   w_in_acc;
    logic                   w_out_free;
    logic                   w_load_total;
    logic [PROFIT_BITS-1:0] w_p;
    logic [CW-1:0]          w_clamp;
    logic [CW-1:0]          w_jb;
    logic                   w_ok;
    logic [VAL_W-1:0]       w_rd_a, w_rd_b;
    logic [VAL_W-1:0]       w_skip, w_base;
    logic [VAL_W-1:0]       w_add_a;
    logic [PROFIT_BITS-1:0] w_add_b;
    logic [SW-1:0]          w_add_full;
    logic [VAL_W-1:0]       w_add;
    logic                   w_row_we;
    logic [DW-1:0]          w_it_rd;
    logic [NC-1:0]          w_tb_take;
    logic [WGT_W-1:0]       w_tb_w;
    logic [PROFIT_BITS-1:0] w_tb_p;
    logic                   w_tb_bit;
    logic [CW-1:0]          w_tb_next_j;
    logic [IW-1:0]          w_tb_idx;

    // handshakes
    assign w_in_acc      = i_item.valid && i_item.ready;
    assign i_item.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign w_out_free    = !r_ov || o_res.ready;

    // profit narrowed or widened to the working width
    generate
        if (PROFIT_BITS <= PRF_IN_W) begin : g_prf_narrow
            assign w_p = i_item.item_profit[PROFIT_BITS-1:0];
        end else begin : g_prf_wide
            assign w_p = {{(PROFIT_BITS-PRF_IN_W){1'b0}}, i_item.item_profit};
        end
    endgenerate

    // traceback start capacity, clamped
    assign w_clamp = (XW'(r_cap) > XW'(MAX_CAPACITY)) ? CW'(MAX_CAPACITY) : CW'(r_cap);

    // sweep read addresses: skip entry j and take source j - weight
    assign w_jb = CW'(XW'(r_j) - XW'(r_w));
    assign w_ok = (r_j != '0) && (XW'(r_j) >= XW'(r_w));

    // best-value row, two copies so both operands read in the same cycle
    kp_ram #(.WIDTH(VAL_W), .DEPTH(NC)) u_row_a (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (r_s1_j),
        .i_wdata (w_add),
        .i_raddr (r_j),
        .o_rdata (w_rd_a)
    );

    kp_ram #(.WIDTH(VAL_W), .DEPTH(NC)) u_row_b (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (r_s1_j),
        .i_wdata (w_add),
        .i_raddr (w_jb),
        .o_rdata (w_rd_b)
    );

    // entries not written in this problem read as zero
    assign w_skip = r_s1_va ? w_rd_a : '0;
    assign w_base = r_s1_vb ? w_rd_b : '0;

    // per-item store: take row, weight, profit
    assign w_tb_idx = r_i - IW'(1);

    kp_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_items (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_STORE),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({r_take, r_w, r_p}),
        .i_raddr (w_tb_idx[AW-1:0]),
        .o_rdata (w_it_rd)
    );

    assign w_tb_take = w_it_rd[DW-1 -: NC];
    assign w_tb_w    = w_it_rd[PROFIT_BITS +: WGT_W];
    assign w_tb_p    = w_it_rd[PROFIT_BITS-1:0];
    assign w_tb_bit  = w_tb_take[r_tj];
    assign w_tb_next_j = (XW'(w_tb_w) <= XW'(r_tj)) ? CW'(XW'(r_tj) - XW'(w_tb_w)) : '0;

    // shared saturating adder: row update during the sweep, running total in traceback
    assign w_add_a    = r_s1_vld ? w_base : r_sum;
    assign w_add_b    = r_s1_vld ? r_p : w_tb_p;
    assign w_add_full = SW'(w_add_a) + SW'(w_add_b);
    assign w_add      = (w_add_full > SW'(VAL_MAX)) ? VAL_MAX : w_add_full[VAL_W-1:0];

    // take only when strictly better than skip
    assign w_row_we = r_s1_vld && r_s1_ok && (w_add > w_skip);

    assign w_load_total = (r_state == ST_TB_CHK) && ((r_i == '0) || (r_tj == '0)) && w_out_free;

    // next-state and datapath logic
    always_comb begin
        n_state  = r_state;
        n_cap    = r_cap;
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_rv     = r_rv;
        n_ov     = r_ov;
        n_w      = r_w;
        n_p      = r_p;
        n_last   = r_last;
        n_j      = r_j;
        n_take   = r_take;
        n_i      = r_i;
        n_tj     = r_tj;
        n_sum    = r_sum;
        n_onum   = r_onum;
        n_osel   = r_osel;
        n_otot   = r_otot;
        n_oovf   = r_oovf;
        n_olast  = r_olast;

        // sweep pipeline stage one
        n_s1_vld = (r_state == ST_SWEEP);
        n_s1_j   = r_j;
        n_s1_ok  = w_ok;
        n_s1_va  = r_rv[r_j];
        n_s1_vb  = r_rv[w_jb];

        if (w_row_we) begin
            n_rv[r_s1_j] = 1'b1;
        end
        if (r_s1_vld) begin
            n_take = {r_take[NC-2:0], w_row_we};
        end

        // configuration write
        if (i_cfg.valid) begin
            n_cap = i_cfg.data;
        end

        // result register drains when taken
        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_w    = i_item.item_weight;
                    n_p    = w_p;
                    n_last = i_item.last_item;
                    if (r_cnt < IW'(MAX_ITEMS)) begin
                        n_j     = CW'(MAX_CAPACITY);
                        n_state = ST_SWEEP;
                    end else begin
                        n_drop = 1'b1;
                        if (i_item.last_item) begin
                            n_i     = r_cnt;
                            n_tj    = w_clamp;
                            n_sum   = '0;
                            n_state = ST_TB_CHK;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                if (r_j == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_j = r_j - CW'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_STORE;
            end
            ST_STORE: begin
                n_cnt = r_cnt + IW'(1);
                if (r_last) begin
                    n_i     = r_cnt + IW'(1);
                    n_tj    = w_clamp;
                    n_sum   = '0;
                    n_state = ST_TB_CHK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_TB_CHK: begin
                if ((r_i == '0) || (r_tj == '0)) begin
                    if (w_out_free) begin
                        n_ov    = 1'b1;
                        n_onum  = '0;
                        n_osel  = 1'b0;
                        n_otot  = r_sum;
                        n_oovf  = r_drop;
                        n_olast = 1'b1;
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_rv    = '0;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_TB_EVAL;
                end
            end
            ST_TB_EVAL: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_onum  = NUM_W'(r_i);
                    n_osel  = w_tb_bit;
                    n_otot  = '0;
                    n_oovf  = 1'b0;
                    n_olast = 1'b0;
                    if (w_tb_bit) begin
                        n_sum = w_add;
                        n_tj  = w_tb_next_j;
                    end
                    n_i     = r_i - IW'(1);
                    n_state = ST_TB_CHK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // registers, control state cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cap    <= '0;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_rv     <= '0;
            r_s1_vld <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cap    <= n_cap;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_rv     <= n_rv;
            r_s1_vld <= n_s1_vld;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_p     <= n_p;
        r_last  <= n_last;
        r_j     <= n_j;
        r_take  <= n_take;
        r_s1_j  <= n_s1_j;
        r_s1_ok <= n_s1_ok;
        r_s1_va <= n_s1_va;
        r_s1_vb <= n_s1_vb;
        r_i     <= n_i;
        r_tj    <= n_tj;
        r_sum   <= n_sum;
        r_onum  <= n_onum;
        r_osel  <= n_osel;
        r_otot  <= n_otot;
        r_oovf  <= n_oovf;
        r_olast <= n_olast;
    end

    // result channel
    assign o_res.valid        = r_ov;
    assign o_res.item_number  = r_onum;
    assign o_res.selected     = r_osel;
    assign o_res.total_profit = r_otot;
    assign o_res.overflow     = r_oovf;
    assign o_res.last_result  = r_olast;

    // checks
    `KP_ASSERT_IMPL(a_row_we_in_sweep, w_row_we, (r_state == ST_SWEEP) || (r_state == ST_DRAIN), "row written outside the sweep")
    `KP_ASSERT(a_cnt_bound, r_cnt <= IW'(MAX_ITEMS), "item count beyond the item store")
    `KP_ASSERT_IMPL(a_tb_eval_live, r_state == ST_TB_EVAL, (r_i != '0) && (r_tj != '0), "traceback step with nothing left")
    `KP_ASSERT_NEXT(a_total_clears, w_load_total, (r_cnt == '0) && (r_rv == '0) && r_ov && r_olast, "problem not cleared after total item")

endmodule
